// File: rtl/core/aes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, s-box tables and round helpers for the aes-128 cipher unit
// ----------------------------------------------------------------------------
package aes_pkg;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_req;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_req;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_DECRYPT  = 2'd2;

    localparam int NUM_ROUNDS = 10;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_KEY_LOAD,
        DP_KEY_STEP,
        DP_CAPTURE,
        DP_LOAD,
        DP_ROUND,
        DP_LAST
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [3:0] rk_addr;
        logic       decrypt;
    } t_dp_cmd;

    function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [3:0] y);
        logic [7:0] acc;
        logic [7:0] v;
        acc = 8'h00;
        v = x;
        for (int b = 0; b < 4; b++) begin
            if (y[b]) acc = acc ^ v;
            v = xtime(v);
        end
        return acc;
    endfunction

    // byte k of the state sits at bits 127-8k
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int k);
        return s[127 - 8*k -: 8];
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8*(c*4+r) -: 8] = fwd_sbox(get_byte(s, ((c + r) % 4)*4 + r));
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8*(((c + r) % 4)*4 + r) -: 8] = inv_sbox(get_byte(s, c*4 + r));
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, c*4);
            a1 = get_byte(s, c*4+1);
            a2 = get_byte(s, c*4+2);
            a3 = get_byte(s, c*4+3);
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 8*(c*4)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[127 - 8*(c*4+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[127 - 8*(c*4+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[127 - 8*(c*4+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a, b, d, e;
        for (int c = 0; c < 4; c++) begin
            a = get_byte(s, c*4);
            b = get_byte(s, c*4+1);
            d = get_byte(s, c*4+2);
            e = get_byte(s, c*4+3);
            t[127 - 8*(c*4)   -: 8] = gf_mul(a, 4'he) ^ gf_mul(b, 4'hb) ^ gf_mul(d, 4'hd)
                                    ^ gf_mul(e, 4'h9);
            t[127 - 8*(c*4+1) -: 8] = gf_mul(a, 4'h9) ^ gf_mul(b, 4'he) ^ gf_mul(d, 4'hb)
                                    ^ gf_mul(e, 4'hd);
            t[127 - 8*(c*4+2) -: 8] = gf_mul(a, 4'hd) ^ gf_mul(b, 4'h9) ^ gf_mul(d, 4'he)
                                    ^ gf_mul(e, 4'hb);
            t[127 - 8*(c*4+3) -: 8] = gf_mul(a, 4'hb) ^ gf_mul(b, 4'hd) ^ gf_mul(d, 4'h9)
                                    ^ gf_mul(e, 4'he);
        end
        return t;
    endfunction

    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {fwd_sbox(w3[23:16]) ^ rc, fwd_sbox(w3[15:8]), fwd_sbox(w3[7:0]),
             fwd_sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/aes128_block_cipher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_block_cipher_unit
// iterative aes-128 ecb cipher, one round per cycle
// ----------------------------------------------------------------------------
// input channel i_in_valid/o_in_ready carries one 128-bit block per request;
// output channel o_out_valid/i_out_ready returns one 128-bit result.
// configuration: i_cfg_we, i_cfg_idx, i_cfg_data; 0 key high, 1 key low,
// 2 direction (bit 0, 1 decrypts). the user must write them only while idle;
// the block itself does not enforce it. a block is registered at accept,
// then passes one load with the first key addition and ten rounds through
// the single round unit before its result is valid. a new block is taken
// only in idle, after the round loop of the previous one has finished.
// after reset or any key write, the first request waits while the schedule
// is expanded into the round-key memory, one key per cycle.
// reset clears control state and configuration only. a stalled result holds
// in the output register; no new block is taken until it can be replaced.
// ----------------------------------------------------------------------------
module aes128_block_cipher_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire aes_pkg::t_in_req  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output aes_pkg::t_out_req      o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [63:0]       i_cfg_data
);
    logic [63:0]      r_key_high;
    logic [63:0]      r_key_low;
    logic             r_decrypt;
    logic             key_write;
    aes_pkg::t_dp_cmd cmd;
    logic             capture;
    logic [127:0]     state;
    aes_pkg::t_out_req r_out;

    assign key_write = i_cfg_we && (i_cfg_idx == aes_pkg::REG_KEY_HIGH
                                 || i_cfg_idx == aes_pkg::REG_KEY_LOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= 64'd0;
            r_key_low  <= 64'd0;
            r_decrypt  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aes_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                aes_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                aes_pkg::REG_DECRYPT:  r_decrypt  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    aes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_key_write (key_write),
        .i_decrypt   (r_decrypt),
        .o_cmd       (cmd),
        .o_capture   (capture)
    );

    aes_datapath u_dp (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_key   ({r_key_high, r_key_low}),
        .i_in    (i_in_data),
        .o_state (state)
    );

    // final round result lands in the cycle after the last op
    logic r_cap_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap_d <= 1'b0;
        else r_cap_d <= capture;
    end

    always_ff @(posedge i_clk) begin
        if (r_cap_d) r_out <= state;
    end

    assign o_out_data = r_cap_d ? aes_pkg::t_out_req'(state) : r_out;
endmodule
`default_nettype wire

// File: rtl/core/aes_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_datapath
// state register, round logic, key expansion and round-key memory
// ----------------------------------------------------------------------------
module aes_datapath (
    input  wire logic             i_clk,
    input  wire aes_pkg::t_dp_cmd i_cmd,
    input  wire logic [127:0]     i_key,
    input  wire aes_pkg::t_in_req i_in,
    output logic [127:0]          o_state
);
    logic [127:0] r_mem [11];
    logic [127:0] r_rk;
    logic [127:0] r_kexp;
    logic [127:0] n_kexp;
    logic [7:0]   r_rc;
    logic [3:0]   r_kaddr;
    logic [127:0] r_state;
    logic [127:0] n_state;

    assign n_kexp = aes_pkg::key_next(r_kexp, r_rc);

    always_comb begin
        n_state = r_state;
        unique case (i_cmd.op)
            aes_pkg::DP_CAPTURE: n_state = {i_in.block_high, i_in.block_low};
            aes_pkg::DP_LOAD: n_state = r_state ^ r_rk;
            aes_pkg::DP_ROUND: begin
                if (i_cmd.decrypt) begin
                    n_state = aes_pkg::inv_mix(aes_pkg::inv_sub_shift(r_state) ^ r_rk);
                end else begin
                    n_state = aes_pkg::mix(aes_pkg::sub_shift(r_state)) ^ r_rk;
                end
            end
            aes_pkg::DP_LAST: begin
                if (i_cmd.decrypt) n_state = aes_pkg::inv_sub_shift(r_state) ^ r_rk;
                else n_state = aes_pkg::sub_shift(r_state) ^ r_rk;
            end
            default: n_state = r_state;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_rk    <= r_mem[i_cmd.rk_addr];
        unique case (i_cmd.op)
            aes_pkg::DP_KEY_LOAD: begin
                r_kexp  <= i_key;
                r_rc    <= 8'h01;
                r_kaddr <= 4'd1;
                r_mem[0] <= i_key;
            end
            aes_pkg::DP_KEY_STEP: begin
                r_kexp  <= n_kexp;
                r_rc    <= aes_pkg::xtime(r_rc);
                r_kaddr <= r_kaddr + 4'd1;
                r_mem[r_kaddr] <= n_kexp;
            end
            default: begin
            end
        endcase
    end

    assign o_state = r_state;
endmodule
`default_nettype wire

// File: rtl/core/aes_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_ctrl
// sequencer for key expansion, rounds and result hand-off
// ----------------------------------------------------------------------------
module aes_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    input  wire logic             i_key_write,
    input  wire logic             i_decrypt,
    output aes_pkg::t_dp_cmd      o_cmd,
    output logic                  o_capture
);
    typedef enum logic [2:0] {
        S_IDLE, S_KEXP, S_PREP, S_LOAD, S_RUN
    } t_state;

    t_state     r_st;
    logic [3:0] r_cnt;
    logic       r_sched;
    logic       r_out_valid;
    logic       r_dec;

    // the round-key read is registered, so the address is issued in the cycle before its op
    assign o_in_ready  = (r_st == S_IDLE) && r_sched && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_capture   = (r_st == S_RUN) && (r_cnt == 4'd10);

    always_comb begin
        o_cmd.op      = aes_pkg::DP_NOP;
        o_cmd.decrypt = r_dec;
        o_cmd.rk_addr = i_decrypt ? 4'd10 : 4'd0;
        unique case (r_st)
            S_IDLE: o_cmd.op = (!r_sched && i_in_valid) ? aes_pkg::DP_KEY_LOAD
                                                        : aes_pkg::DP_NOP;
            S_KEXP: o_cmd.op = aes_pkg::DP_KEY_STEP;
            S_PREP: o_cmd.op = aes_pkg::DP_NOP;
            S_LOAD: begin
                o_cmd.op = aes_pkg::DP_LOAD;
                o_cmd.rk_addr = r_dec ? 4'd9 : 4'd1;
            end
            S_RUN: begin
                o_cmd.op = (r_cnt == 4'd10) ? aes_pkg::DP_LAST : aes_pkg::DP_ROUND;
                o_cmd.rk_addr = r_dec ? 4'd9 - r_cnt : r_cnt + 4'd1;
            end
            default: o_cmd.op = aes_pkg::DP_NOP;
        endcase
        if (r_st == S_IDLE && o_in_ready && i_in_valid) o_cmd.op = aes_pkg::DP_CAPTURE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_cnt       <= 4'd0;
            r_sched     <= 1'b0;
            r_out_valid <= 1'b0;
            r_dec       <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_key_write) r_sched <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (o_in_ready && i_in_valid) begin
                        r_dec <= i_decrypt;
                        r_st  <= S_LOAD;
                    end else if (!r_sched && i_in_valid) begin
                        r_cnt <= 4'd1;
                        r_st  <= S_KEXP;
                    end
                end
                S_KEXP: begin
                    if (r_cnt == 4'd10) begin
                        r_sched <= 1'b1;
                        r_st    <= S_PREP;
                    end
                    r_cnt <= r_cnt + 4'd1;
                end
                S_PREP: r_st <= S_IDLE;
                S_LOAD: begin
                    r_cnt <= 4'd1;
                    r_st  <= S_RUN;
                end
                S_RUN: begin
                    if (r_cnt == 4'd10) begin
                        r_out_valid <= 1'b1;
                        r_st <= S_IDLE;
                    end
                    r_cnt <= r_cnt + 4'd1;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_capture_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_capture |=> o_out_valid) else $error("result not presented");
    a_no_accept_unsched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_sched) else $error("accepted without schedule");
    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RUN) |-> (r_cnt >= 4'd1 && r_cnt <= 4'd10)) else $error("round count");
endmodule
`default_nettype wire

// File: tb/tb_aes128_block_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes128_block_cipher_unit
// checks the aes-128 ecb unit against a behavioural cipher: known vectors,
// several keys and both directions, random blocks under random handshake gaps
// ----------------------------------------------------------------------------
class aes_scoreboard;
    aes_pkg::t_out_req expected_q[$];
    int errors = 0;

    function void note_request(aes_pkg::t_out_req r);
        expected_q.push_back(r);
    endfunction

    function void check_result(aes_pkg::t_out_req got);
        aes_pkg::t_out_req want;
        if (expected_q.size() == 0) begin
            $display("%0t unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (want.result_high !== got.result_high) begin
            $display("%0t result_high expected %h actual %h", $time, want.result_high,
                     got.result_high);
            errors++;
        end
        if (want.result_low !== got.result_low) begin
            $display("%0t result_low expected %h actual %h", $time, want.result_low,
                     got.result_low);
            errors++;
        end
    endfunction
endclass

module tb_aes128_block_cipher_unit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    aes_pkg::t_in_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    aes_pkg::t_out_req o_out_data;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    aes128_block_cipher_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    aes_scoreboard sb = new();

    logic [63:0] key_hi_r = '0, key_lo_r = '0;
    logic        dec_r = 1'b0;
    logic [7:0]  sbox_f [256];
    logic [7:0]  sbox_i [256];
    logic [127:0] round_keys [11];
    int   rx_mode = 0;   // 0 random, 1 never stall, 2 long hold-off

    function automatic logic [7:0] dbl8(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(logic [7:0] x, logic [7:0] y);
        logic [7:0] acc;
        acc = 0;
        for (int b = 0; b < 8; b++) begin
            if (y[b]) acc ^= x;
            x = dbl8(x);
        end
        return acc;
    endfunction

    function automatic void build_sboxes();
        logic [7:0] inv, p, s;
        for (int x = 0; x < 256; x++) begin
            inv = 0;
            for (int y = 1; y < 256; y++)
                if (gmul(x, y) == 8'h01) inv = y;
            s = inv;
            p = inv;
            for (int k = 0; k < 4; k++) begin
                p = {p[6:0], p[7]};
                s ^= p;
            end
            s ^= 8'h63;
            sbox_f[x] = s;
            sbox_i[s] = x;
        end
    endfunction

    function automatic void expand_schedule();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0] rc;
        logic [127:0] k;
        k = {key_hi_r, key_lo_r};
        rc = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = k[127 - 32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {sbox_f[t[23:16]] ^ rc, sbox_f[t[15:8]], sbox_f[t[7:0]],
                     sbox_f[t[31:24]]};
                rc = dbl8(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++)
            round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function automatic aes_pkg::t_out_req cipher_block(aes_pkg::t_in_req blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] v;
        aes_pkg::t_out_req res;
        v = blk;
        for (int k = 0; k < 16; k++) s[k] = v[127 - 8*k -: 8];
        for (int step = 0; step <= 10; step++) begin
            int rk;
            rk = dec_r ? 10 - step : step;
            if (step > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        if (dec_r) t[((c + r) % 4)*4 + r] = sbox_i[s[c*4 + r]];
                        else t[c*4 + r] = sbox_f[s[((c + r) % 4)*4 + r]];
                s = t;
                if (!dec_r && step < 10)
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        s[4*c]   = gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3;
                        s[4*c+1] = a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3;
                        s[4*c+2] = a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3);
                        s[4*c+3] = gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2);
                    end
            end
            for (int k = 0; k < 16; k++) s[k] ^= round_keys[rk][127 - 8*k -: 8];
            if (dec_r && step > 0 && step < 10)
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = gmul(a0, 14) ^ gmul(a1, 11) ^ gmul(a2, 13) ^ gmul(a3, 9);
                    s[4*c+1] = gmul(a0, 9) ^ gmul(a1, 14) ^ gmul(a2, 11) ^ gmul(a3, 13);
                    s[4*c+2] = gmul(a0, 13) ^ gmul(a1, 9) ^ gmul(a2, 14) ^ gmul(a3, 11);
                    s[4*c+3] = gmul(a0, 11) ^ gmul(a1, 13) ^ gmul(a2, 9) ^ gmul(a3, 14);
                end
        end
        for (int k = 0; k < 16; k++) v[127 - 8*k -: 8] = s[k];
        res = v;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // idle between phases, then write one register
    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            aes_pkg::REG_KEY_HIGH: key_hi_r = val;
            aes_pkg::REG_KEY_LOW:  key_lo_r = val;
            aes_pkg::REG_DECRYPT:  dec_r = val[0];
            default: ;
        endcase
        if (idx == aes_pkg::REG_KEY_HIGH || idx == aes_pkg::REG_KEY_LOW) expand_schedule();
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit gaps);
        aes_pkg::t_in_req blk;
        if (gaps)
            while ($urandom_range(99) < 19) @(negedge i_clk);
        blk.block_high = hi;
        blk.block_low = lo;
        i_in_valid = 1'b1;
        i_in_data = blk;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(cipher_block(blk));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);

    initial begin : receiver
        int hold;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_mode == 2) begin
                i_out_ready = 1'b0;
                for (hold = 0; hold < 400; hold++) @(negedge i_clk);
                rx_mode = 0;
            end
            i_out_ready = (rx_mode == 1) ? 1'b1 : ($urandom_range(99) >= 19);
        end
    end

    initial begin : stimulus
        logic [63:0] keys [4][2];
        build_sboxes();
        expand_schedule();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // all-zero key, nothing written yet
        send_block('0, '0, 0);
        send_block('1, '1, 0);
        wait_drained();
        // known vector of the standard
        write_reg(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
        write_reg(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 0);
        send_block('1, '0, 0);
        wait_drained();
        write_reg(aes_pkg::REG_DECRYPT, 64'h1);
        send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 0);
        send_block('0, '1, 0);
        wait_drained();
        // only bit 0 of the direction counts
        write_reg(aes_pkg::REG_DECRYPT, 64'hfffffffffffffffe);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 0);
        wait_drained();
        // partial key change, then unused index
        write_reg(aes_pkg::REG_KEY_LOW, '1);
        write_reg(2'd3, '1);
        send_block('0, '0, 0);
        wait_drained();
        write_reg(aes_pkg::REG_KEY_HIGH, '1);
        write_reg(aes_pkg::REG_DECRYPT, 64'h1);
        send_block('1, '1, 0);
        send_block(64'h8000000000000001, 64'h8000000000000001, 0);
        wait_drained();

        // random phases over several keys and both directions
        keys[0][0] = '0; keys[0][1] = '0;
        keys[1][0] = '1; keys[1][1] = '1;
        keys[2][0] = rand64(); keys[2][1] = rand64();
        keys[3][0] = rand64(); keys[3][1] = rand64();
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(aes_pkg::REG_KEY_HIGH, keys[ph % 4][0]);
            write_reg(aes_pkg::REG_KEY_LOW, keys[ph % 4][1]);
            write_reg(aes_pkg::REG_DECRYPT, {$urandom(), $urandom()});
            rx_mode = (ph == 3) ? 1 : (ph == 5) ? 2 : 0;
            for (int n = 0; n < 150; n++)
                send_block(rand64(), rand64(), ph != 3);
            if (ph == 6) wait_drained();
            else wait_drained();
        end
        rx_mode = 0;
        wait_drained();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule
